>>> hw/rtl/valve_and_cassette_positioner_assert.svh
// ----------------------------------------------------------------------------
// valve and cassette positioner assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef VALVE_AND_CASSETTE_POSITIONER_ASSERT_SVH
`define VALVE_AND_CASSETTE_POSITIONER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vcp assertion failed");
// next-cycle implication
`define VCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vcp assertion failed");
`else
`define VCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// shared types, codes and helpers of the valve and cassette positioner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcp_pkg;

	localparam int TIMER_BITS   = 16;
	localparam int CFG_BITS     = 16;
	localparam int ELAPSED_BITS = 10;
	localparam int ADDR_BITS    = 4;
	localparam int DATA_BITS    = 32;
	localparam int SUM_BITS     = (TIMER_BITS > ELAPSED_BITS ? TIMER_BITS : ELAPSED_BITS) + 1;
	localparam int CMP_BITS     = (TIMER_BITS > CFG_BITS ? TIMER_BITS : CFG_BITS);

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// device codes
	localparam logic [2:0] DEV_NONE     = 3'd0;
	localparam logic [2:0] DEV_RBC      = 3'd1;
	localparam logic [2:0] DEV_PLASMA   = 3'd2;
	localparam logic [2:0] DEV_PLATELET = 3'd3;
	localparam logic [2:0] DEV_CASSETTE = 3'd4;

	// motor commands
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_STOP = 2'd1;
	localparam logic [1:0] CMD_CW   = 2'd2;
	localparam logic [1:0] CMD_CCW  = 2'd3;

	// valve positions
	localparam logic [1:0] POS_UNKNOWN = 2'd0;
	localparam logic [1:0] POS_COLLECT = 2'd1;
	localparam logic [1:0] POS_OPEN    = 2'd2;
	localparam logic [1:0] POS_RETURN  = 2'd3;

	// cassette positions
	localparam logic [1:0] CAS_NONE = 2'd0;
	localparam logic [1:0] CAS_UP   = 2'd1;
	localparam logic [1:0] CAS_DOWN = 2'd2;

	// register indexes
	localparam logic [1:0] REG_VALVE_TIMEOUT    = 2'd0;
	localparam logic [1:0] REG_CASSETTE_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_OVERDRIVE        = 2'd2;
	localparam logic [1:0] REG_HOLDOFF          = 2'd3;

	// register reset values
	localparam logic [CFG_BITS-1:0] RST_VALVE_TIMEOUT    = 16'd1400;
	localparam logic [CFG_BITS-1:0] RST_CASSETTE_TIMEOUT = 16'd8000;
	localparam logic [CFG_BITS-1:0] RST_OVERDRIVE        = 16'd500;
	localparam logic [CFG_BITS-1:0] RST_HOLDOFF          = 16'd15;

	typedef struct packed {
		logic [CFG_BITS-1:0] valve_timeout_ms;
		logic [CFG_BITS-1:0] cassette_timeout_ms;
		logic [CFG_BITS-1:0] overdrive_ms;
		logic [CFG_BITS-1:0] holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic [ELAPSED_BITS-1:0] elapsed_ms;
		logic [1:0]              rbc_order;
		logic [1:0]              rbc_status;
		logic [1:0]              plasma_order;
		logic [1:0]              plasma_status;
		logic [1:0]              platelet_order;
		logic [1:0]              platelet_status;
		logic [1:0]              cassette_order;
		logic [1:0]              cassette_status;
		logic                    cassette_motor_fault;
	} item_t;

	typedef struct packed {
		logic [2:0] device_select;
		logic [1:0] motor_command;
		logic       order_writeback;
		logic [2:0] active_device;
		logic       cassette_error;
		logic       holdoff_busy;
	} result_t;

	// saturating timer add
	function automatic logic [TIMER_BITS-1:0] timer_add(
		input logic [TIMER_BITS-1:0]   t,
		input logic [ELAPSED_BITS-1:0] d
	);
		logic [SUM_BITS-1:0] s;
		s = SUM_BITS'(t) + SUM_BITS'(d);
		if (s > SUM_BITS'(TIMER_MAX)) begin
			return TIMER_MAX;
		end
		return TIMER_BITS'(s);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vcp_stream_if.sv
// ----------------------------------------------------------------------------
// vcp stream interfaces
// valid/ready channels for control ticks and motor results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vcp_tick_if import vcp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ELAPSED_BITS-1:0] elapsed_ms;
	logic [1:0]              rbc_order;
	logic [1:0]              rbc_status;
	logic [1:0]              plasma_order;
	logic [1:0]              plasma_status;
	logic [1:0]              platelet_order;
	logic [1:0]              platelet_status;
	logic [1:0]              cassette_order;
	logic [1:0]              cassette_status;
	logic                    cassette_motor_fault;

	modport source (
		output valid, elapsed_ms, rbc_order, rbc_status, plasma_order, plasma_status,
			platelet_order, platelet_status, cassette_order, cassette_status,
			cassette_motor_fault,
		input  ready
	);
	modport sink (
		input  valid, elapsed_ms, rbc_order, rbc_status, plasma_order, plasma_status,
			platelet_order, platelet_status, cassette_order, cassette_status,
			cassette_motor_fault,
		output ready
	);
endinterface

interface vcp_result_if ();
	logic       valid;
	logic       ready;
	logic [2:0] device_select;
	logic [1:0] motor_command;
	logic       order_writeback;
	logic [2:0] active_device;
	logic       cassette_error;
	logic       holdoff_busy;

	modport source (
		output valid, device_select, motor_command, order_writeback, active_device,
			cassette_error, holdoff_busy,
		input  ready
	);
	modport sink (
		input  valid, device_select, motor_command, order_writeback, active_device,
			cassette_error, holdoff_busy,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/valve_and_cassette_positioner.sv
// ----------------------------------------------------------------------------
// valve_and_cassette_positioner
// one motor command per control tick for three rotary valves and a cassette
// ----------------------------------------------------------------------------
// Every control tick that arrives on the tick channel produces exactly one
// result transaction. The block takes one tick per clock cycle while the result
// channel keeps taking results; a tick is registered in the tick register on
// acceptance, and the state update and motor decision run between that register
// and the result register, which loads the result once it is free or being
// drained. A stall on the result channel holds the tick in the tick register.
// The result register lets a new tick be taken while a finished result still
// waits to be taken. Timeout, overdrive and holdoff settings sit on the apb
// port at byte addresses 0, 4, 8 and 12 and are meant to be written while no
// tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module valve_and_cassette_positioner import vcp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	// streams
	vcp_tick_if.sink                  tick,
	vcp_result_if.source              result
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_n;
	result_t res_q;
	logic    res_valid_q;

	vcp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tick moves on when the result register is free or being drained
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	// tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1.elapsed_ms           <= tick.elapsed_ms;
			item_s1.rbc_order            <= tick.rbc_order;
			item_s1.rbc_status           <= tick.rbc_status;
			item_s1.plasma_order         <= tick.plasma_order;
			item_s1.plasma_status        <= tick.plasma_status;
			item_s1.platelet_order       <= tick.platelet_order;
			item_s1.platelet_status      <= tick.platelet_status;
			item_s1.cassette_order       <= tick.cassette_order;
			item_s1.cassette_status      <= tick.cassette_status;
			item_s1.cassette_motor_fault <= tick.cassette_motor_fault;
		end
	end

	// motion state and decision logic
	vcp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_n)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.device_select   = res_q.device_select;
	assign result.motor_command   = res_q.motor_command;
	assign result.order_writeback = res_q.order_writeback;
	assign result.active_device   = res_q.active_device;
	assign result.cassette_error  = res_q.cassette_error;
	assign result.holdoff_busy    = res_q.holdoff_busy;

endmodule

`default_nettype wire

>>> hw/rtl/vcp_apb_regs.sv
// ----------------------------------------------------------------------------
// vcp_apb_regs
// apb register file holding the timeout, overdrive and holdoff settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcp_apb_regs import vcp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valve_timeout_ms    <= RST_VALVE_TIMEOUT;
			cfg_q.cassette_timeout_ms <= RST_CASSETTE_TIMEOUT;
			cfg_q.overdrive_ms        <= RST_OVERDRIVE;
			cfg_q.holdoff_ms          <= RST_HOLDOFF;
		end else if (wr_en) begin
			case (reg_idx)
				REG_VALVE_TIMEOUT:    cfg_q.valve_timeout_ms    <= pwdata[CFG_BITS-1:0];
				REG_CASSETTE_TIMEOUT: cfg_q.cassette_timeout_ms <= pwdata[CFG_BITS-1:0];
				REG_OVERDRIVE:        cfg_q.overdrive_ms        <= pwdata[CFG_BITS-1:0];
				REG_HOLDOFF:          cfg_q.holdoff_ms          <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_VALVE_TIMEOUT:    prdata = DATA_BITS'(cfg_q.valve_timeout_ms);
			REG_CASSETTE_TIMEOUT: prdata = DATA_BITS'(cfg_q.cassette_timeout_ms);
			REG_OVERDRIVE:        prdata = DATA_BITS'(cfg_q.overdrive_ms);
			REG_HOLDOFF:          prdata = DATA_BITS'(cfg_q.holdoff_ms);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/vcp_ctrl.sv
// ----------------------------------------------------------------------------
// vcp_ctrl
// per-tick state update: move supervision, holdoff and order arbitration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "valve_and_cassette_positioner_assert.svh"

module vcp_ctrl import vcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  advance,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	logic [2:0]            moving_q,   moving_n;
	logic [TIMER_BITS-1:0] move_tmr_q, move_tmr_n;
	logic                  pause_q,    pause_n;
	logic [TIMER_BITS-1:0] pause_tmr_q, pause_tmr_n;
	logic [1:0]            vtgt_q [3];
	logic [1:0]            vtgt_n [3];
	logic                  vccw_q [3];
	logic                  vccw_n [3];
	logic                  vto_q  [3];
	logic                  vto_n  [3];
	logic [1:0]            start_pos_q, start_pos_n;
	logic [1:0]            cas_tgt_q,   cas_tgt_n;
	logic                  od_q,        od_n;
	logic [TIMER_BITS-1:0] od_tmr_q,    od_tmr_n;
	logic                  fault_q,     fault_n;

	logic [1:0] vord [3];
	logic [1:0] vsta [3];
	logic [2:0] need;
	logic [1:0] k;
	logic [1:0] pick;
	logic [1:0] vo, vs, po, ps;
	logic       stop, was_moving, ccw;
	logic [2:0] sel;
	logic [1:0] cmd;
	logic       wb;

	assign vord[0] = item.rbc_order;
	assign vord[1] = item.plasma_order;
	assign vord[2] = item.platelet_order;
	assign vsta[0] = item.rbc_status;
	assign vsta[1] = item.plasma_status;
	assign vsta[2] = item.platelet_status;

	// valves that want a move, lowest index wins
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			need[i] = (vord[i] != vsta[i]) && (vord[i] != POS_UNKNOWN);
		end
		if (need[0]) begin
			pick = 2'd0;
		end else if (need[1]) begin
			pick = 2'd1;
		end else begin
			pick = 2'd2;
		end
	end

	assign k  = moving_q[1:0] - 2'd1;
	assign vo = vord[k];
	assign vs = vsta[k];
	assign po = vord[pick];
	assign ps = vsta[pick];

	always_comb begin
		moving_n    = moving_q;
		move_tmr_n  = (moving_q != DEV_NONE) ? timer_add(move_tmr_q, item.elapsed_ms)
			: move_tmr_q;
		od_tmr_n    = od_q ? timer_add(od_tmr_q, item.elapsed_ms) : od_tmr_q;
		pause_tmr_n = pause_q ? timer_add(pause_tmr_q, item.elapsed_ms) : pause_tmr_q;
		pause_n     = pause_q;
		start_pos_n = start_pos_q;
		cas_tgt_n   = cas_tgt_q;
		od_n        = od_q;
		fault_n     = fault_q;
		for (int i = 0; i < 3; i++) begin
			vtgt_n[i] = vtgt_q[i];
			vccw_n[i] = vccw_q[i];
			vto_n[i]  = vto_q[i];
		end
		sel        = DEV_NONE;
		cmd        = CMD_NONE;
		wb         = 1'b0;
		stop       = 1'b0;
		ccw        = 1'b0;
		was_moving = (moving_q != DEV_NONE);

		// supervise the device in motion
		if (moving_q inside {DEV_RBC, DEV_PLASMA, DEV_PLATELET}) begin
			if (vo == vs) begin
				stop = 1'b1;
			end else if (vs != start_pos_q && vs != POS_UNKNOWN) begin
				stop = 1'b1;
			end else if (CMP_BITS'(move_tmr_n) > CMP_BITS'(cfg.valve_timeout_ms)) begin
				stop     = 1'b1;
				wb       = 1'b1;
				vto_n[k] = 1'b1;
			end
		end else if (moving_q == DEV_CASSETTE) begin
			if (item.cassette_order == item.cassette_status) begin
				if (!od_q) begin
					od_n     = 1'b1;
					od_tmr_n = '0;
				end else if (CMP_BITS'(od_tmr_n) >= CMP_BITS'(cfg.overdrive_ms)) begin
					stop = 1'b1;
				end
			end else if (item.cassette_motor_fault) begin
				stop    = 1'b1;
				fault_n = 1'b1;
				wb      = 1'b1;
			end else if (cas_tgt_q != item.cassette_order) begin
				stop = 1'b1;
			end else if (CMP_BITS'(move_tmr_n) > CMP_BITS'(cfg.cassette_timeout_ms)) begin
				stop    = 1'b1;
				fault_n = 1'b1;
				wb      = 1'b1;
			end
		end else begin
			moving_n = DEV_NONE;
		end

		if (stop) begin
			sel         = moving_q;
			cmd         = CMD_STOP;
			moving_n    = DEV_NONE;
			pause_n     = 1'b1;
			pause_tmr_n = '0;
		end

		if (pause_n && CMP_BITS'(pause_tmr_n) >= CMP_BITS'(cfg.holdoff_ms)) begin
			pause_n = 1'b0;
		end

		// serve a new order
		if (!was_moving && moving_n == DEV_NONE && !pause_n) begin
			if (|need) begin
				if (vtgt_q[pick] == po && ps == POS_UNKNOWN && vto_q[pick]) begin
					ccw = !vccw_q[pick];
				end else if (po == POS_COLLECT) begin
					ccw = 1'b1;
				end else if (po == POS_OPEN) begin
					ccw = (ps != POS_COLLECT);
				end else begin
					ccw = 1'b0;
				end
				start_pos_n  = ps;
				vtgt_n[pick] = po;
				vccw_n[pick] = ccw;
				vto_n[pick]  = 1'b0;
				move_tmr_n   = '0;
				moving_n     = 3'(pick) + 3'd1;
				sel          = 3'(pick) + 3'd1;
				cmd          = ccw ? CMD_CCW : CMD_CW;
			end else if (item.cassette_order != item.cassette_status &&
				(item.cassette_order == CAS_UP || item.cassette_order == CAS_DOWN)) begin
				fault_n    = 1'b0;
				od_n       = 1'b0;
				move_tmr_n = '0;
				cas_tgt_n  = item.cassette_order;
				moving_n   = DEV_CASSETTE;
				sel        = DEV_CASSETTE;
				cmd        = (item.cassette_order == CAS_UP) ? CMD_CCW : CMD_CW;
			end
		end

		res.device_select   = sel;
		res.motor_command   = cmd;
		res.order_writeback = wb;
		res.active_device   = moving_n;
		res.cassette_error  = fault_n;
		res.holdoff_busy    = pause_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q    <= DEV_NONE;
			move_tmr_q  <= '0;
			pause_q     <= 1'b0;
			pause_tmr_q <= '0;
			start_pos_q <= POS_UNKNOWN;
			cas_tgt_q   <= CAS_NONE;
			od_q        <= 1'b0;
			od_tmr_q    <= '0;
			fault_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				vtgt_q[i] <= POS_UNKNOWN;
				vccw_q[i] <= 1'b0;
				vto_q[i]  <= 1'b0;
			end
		end else if (advance) begin
			moving_q    <= moving_n;
			move_tmr_q  <= move_tmr_n;
			pause_q     <= pause_n;
			pause_tmr_q <= pause_tmr_n;
			start_pos_q <= start_pos_n;
			cas_tgt_q   <= cas_tgt_n;
			od_q        <= od_n;
			od_tmr_q    <= od_tmr_n;
			fault_q     <= fault_n;
			for (int i = 0; i < 3; i++) begin
				vtgt_q[i] <= vtgt_n[i];
				vccw_q[i] <= vccw_n[i];
				vto_q[i]  <= vto_n[i];
			end
		end
	end

	// a stop always leaves nothing moving
	`VCP_ASSERT_NXT(a_stop_idles, clk, arst_n,
		advance && res.motor_command == CMD_STOP, moving_q == DEV_NONE)
	// a start makes the selected device the moving one
	`VCP_ASSERT_NXT(a_start_moves, clk, arst_n,
		advance && (res.motor_command == CMD_CW || res.motor_command == CMD_CCW),
		moving_q == $past(res.device_select))
	// state only changes on an accepted tick
	`VCP_ASSERT_NXT(a_hold_state, clk, arst_n, !advance,
		$stable(moving_q) && $stable(move_tmr_q) && $stable(pause_q))
	// a cassette writeback leaves the error flag set
	`VCP_ASSERT_NXT(a_cas_error, clk, arst_n,
		advance && res.order_writeback && res.device_select == DEV_CASSETTE, fault_q)

endmodule

`default_nettype wire
